@@ rtl/ets_pkg.sv @@
// ----------------------------------------------------------------------------
// ets_pkg
// Shared types and codes for the EEPROM transfer splitter.
// ----------------------------------------------------------------------------
package ets_pkg;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_ZERO_LEN = 2'd1,
      STATUS_RANGE    = 2'd2
   } status_type;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // register index taken from paddr[2]
   localparam logic REG_DEVICE_BASE = 1'b0;
   localparam logic [6:0] DEVICE_BASE_RESET = 7'h54;

   localparam int MAX_RESULTS = 64;
   localparam int CNT_W       = $clog2(MAX_RESULTS);
   localparam int SEG_W       = 9;
   localparam int OFF_W       = 10;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      status_type  status;
      logic        op;
      logic [15:0] addr;
      logic [15:0] len;
      logic        trunc;
   } job_type;

endpackage

@@ rtl/ets_front.sv @@
// ----------------------------------------------------------------------------
// ets_front
// Accepts requests, checks range and length, clips at the chip end and flags
// requests that need more segments than the result limit.
// ----------------------------------------------------------------------------
module ets_front
   import ets_pkg::*;
#(
   parameter int PAGE_BYTES  = 16,
   parameter int BLOCK_BYTES = 256,
   parameter int BLOCK_COUNT = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [15:0] req_start_address,
   input  logic [15:0] req_length,
   output logic        push_valid,
   input  logic        push_ready,
   output job_type     push_job
);

   localparam int CHIP   = BLOCK_BYTES * BLOCK_COUNT;
   localparam int POS_W  = $clog2(CHIP + 1);
   localparam int PAGE_L = $clog2(PAGE_BYTES);
   localparam int WORD_L = $clog2(BLOCK_BYTES);
   localparam int UNIT_L = (PAGE_L < WORD_L) ? PAGE_L : WORD_L;

   logic             a_valid_ff, a_valid_in;
   status_type       a_status_ff, a_status_in;
   logic             a_op_ff;
   logic [POS_W-1:0] a_addr_ff, a_addr_in;
   logic [POS_W-1:0] a_len_ff, a_len_in;
   logic             a_trunc_ff, a_trunc_in;

   logic             b_valid_ff, b_valid_in;
   job_type          b_job_ff, b_job_in;

   logic             b_adv, a_take, req_take;
   logic             range_err, zero_err, clip;
   logic [15:0]      room;
   logic [POS_W-1:0] end_pos, units;
   logic             over_limit;

   assign b_adv     = !b_valid_ff || push_ready;
   assign a_take    = a_valid_ff && b_adv;
   assign req_ready = !a_valid_ff || b_adv;
   assign req_take  = req_valid && req_ready;

   // classify
   always_comb begin
      range_err = req_start_address >= 16'(CHIP);
      zero_err  = req_length == 16'd0;
      room      = 16'(CHIP) - req_start_address;
      clip      = req_length > room;
      if (range_err) begin
         a_status_in = STATUS_RANGE;
      end else if (zero_err) begin
         a_status_in = STATUS_ZERO_LEN;
      end else begin
         a_status_in = STATUS_OK;
      end
      a_addr_in  = POS_W'(req_start_address);
      a_len_in   = clip ? POS_W'(room) : POS_W'(req_length);
      a_trunc_in = clip && !range_err && !zero_err;
      a_valid_in = req_take ? 1'b1 : (a_take ? 1'b0 : a_valid_ff);
   end

   // segment count check against the result limit
   always_comb begin
      end_pos    = a_addr_ff + a_len_ff - POS_W'(1);
      units      = (end_pos >> UNIT_L) - (a_addr_ff >> UNIT_L) + POS_W'(1);
      over_limit = 16'(units) > 16'(MAX_RESULTS);
      b_job_in.status = a_status_ff;
      b_job_in.op     = a_op_ff;
      b_job_in.addr   = 16'(a_addr_ff);
      b_job_in.len    = 16'(a_len_ff);
      b_job_in.trunc  = a_trunc_ff ||
                        ((a_status_ff == STATUS_OK) && (a_op_ff == OP_WRITE) && over_limit);
      b_valid_in = a_take ? 1'b1 : (push_ready ? 1'b0 : b_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         a_status_ff <= a_status_in;
         a_op_ff     <= req_op;
         a_addr_ff   <= a_addr_in;
         a_len_ff    <= a_len_in;
         a_trunc_ff  <= a_trunc_in;
      end
      if (a_take) begin
         b_job_ff <= b_job_in;
      end
   end

   assign push_valid = b_valid_ff;
   assign push_job   = b_job_ff;

endmodule

@@ rtl/ets_queue.sv @@
// ----------------------------------------------------------------------------
// ets_queue
// Short item queue between the front and the segment sequencer.
// ----------------------------------------------------------------------------
module ets_queue
   import ets_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_job,
   output logic    pop_valid,
   input  logic    pop_ready,
   output job_type pop_job
);

   job_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push, pop;

   assign push_ready = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_job    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_count_push: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + QCNT_W'(1)))
      else $error("queue count did not follow push");
`endif

endmodule

@@ rtl/ets_back.sv @@
// ----------------------------------------------------------------------------
// ets_back
// Segment sequencer: walks one queued item and emits one bus transfer per
// cycle into the result register while that register is free.
// ----------------------------------------------------------------------------
module ets_back
   import ets_pkg::*;
#(
   parameter int PAGE_BYTES  = 16,
   parameter int BLOCK_BYTES = 256,
   parameter int BLOCK_COUNT = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [6:0]  device_base,
   input  logic        pop_valid,
   output logic        pop_ready,
   input  job_type     pop_job,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [6:0]  rsp_device_address,
   output logic [7:0]  rsp_word_address,
   output logic [8:0]  rsp_segment_length,
   output logic [9:0]  rsp_buffer_offset,
   output logic [1:0]  rsp_status,
   output logic        rsp_truncated,
   output logic        rsp_last
);

   localparam int CHIP   = BLOCK_BYTES * BLOCK_COUNT;
   localparam int POS_W  = $clog2(CHIP + 1);
   localparam int WORD_W = $clog2(BLOCK_BYTES);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } back_state_type;

   back_state_type     state_ff, state_in;
   status_type         status_ff;
   logic               op_ff, trunc_ff;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [POS_W-1:0]   left_ff, left_in;
   logic [OFF_W-1:0]   off_ff, off_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [6:0]         dev_ff, dev_in;
   logic [7:0]         word_ff, word_in;
   logic [SEG_W-1:0]   seg_ff, seg_in;
   logic [OFF_W-1:0]   roff_ff, roff_in;
   status_type         rstat_ff, rstat_in;
   logic               rtrunc_ff, rtrunc_in;
   logic               last_ff, last_in;

   logic               out_free, emit, load;
   logic [WORD_W-1:0]  word;
   logic [SEG_W-1:0]   blk_left, page_off, page_left, seg_a, seg;
   logic               seg_last;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop_ready = state_ff == ST_IDLE;
   assign load      = pop_valid && pop_ready;
   assign emit      = (state_ff == ST_RUN) && out_free;

   // next segment
   always_comb begin
      word      = pos_ff[WORD_W-1:0];
      blk_left  = SEG_W'(BLOCK_BYTES) - SEG_W'(word);
      page_off  = SEG_W'(word) & SEG_W'(PAGE_BYTES - 1);
      page_left = SEG_W'(PAGE_BYTES) - page_off;
      seg_a     = ((op_ff == OP_WRITE) && (page_left < blk_left)) ? page_left : blk_left;
      seg       = (16'(left_ff) < 16'(seg_a)) ? SEG_W'(left_ff) : seg_a;
      seg_last  = (16'(left_ff) == 16'(seg)) || (cnt_ff == CNT_W'(MAX_RESULTS - 1));
   end

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      left_in  = left_ff;
      off_in   = off_ff;
      cnt_in   = cnt_ff;
      dev_in    = dev_ff;
      word_in   = word_ff;
      seg_in    = seg_ff;
      roff_in   = roff_ff;
      rstat_in  = rstat_ff;
      rtrunc_in = rtrunc_ff;
      last_in   = last_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (load) begin
               pos_in   = POS_W'(pop_job.addr);
               left_in  = POS_W'(pop_job.len);
               off_in   = '0;
               cnt_in   = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (emit) begin
               rsp_valid_in = 1'b1;
               rstat_in     = status_ff;
               if (status_ff != STATUS_OK) begin
                  dev_in    = '0;
                  word_in   = '0;
                  seg_in    = '0;
                  roff_in   = '0;
                  rtrunc_in = 1'b0;
                  last_in   = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  dev_in    = device_base + 7'(pos_ff >> WORD_W);
                  word_in   = 8'(word);
                  seg_in    = seg;
                  roff_in   = off_ff;
                  rtrunc_in = trunc_ff;
                  last_in   = seg_last;
                  pos_in    = pos_ff + POS_W'(seg);
                  left_in   = left_ff - POS_W'(seg);
                  off_in    = off_ff + OFF_W'(seg);
                  cnt_in    = cnt_ff + CNT_W'(1);
                  if (seg_last) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff <= pop_job.status;
         op_ff     <= pop_job.op;
         trunc_ff  <= pop_job.trunc;
      end
      pos_ff    <= pos_in;
      left_ff   <= left_in;
      off_ff    <= off_in;
      cnt_ff    <= cnt_in;
      dev_ff    <= dev_in;
      word_ff   <= word_in;
      seg_ff    <= seg_in;
      roff_ff   <= roff_in;
      rstat_ff  <= rstat_in;
      rtrunc_ff <= rtrunc_in;
      last_ff   <= last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_device_address = dev_ff;
   assign rsp_word_address   = word_ff;
   assign rsp_segment_length = seg_ff;
   assign rsp_buffer_offset  = roff_ff;
   assign rsp_status         = rstat_ff;
   assign rsp_truncated      = rtrunc_ff;
   assign rsp_last           = last_ff;

`ifndef NO_ASSERTIONS
   a_error_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rstat_ff != STATUS_OK)) |-> (last_ff && (seg_ff == '0)))
      else $error("error item not a single empty result");

   a_ok_nonempty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rstat_ff == STATUS_OK)) |-> (seg_ff != '0))
      else $error("empty segment emitted");
`endif

endmodule

@@ rtl/eeprom_transfer_splitter_core.sv @@
// ----------------------------------------------------------------------------
// eeprom_transfer_splitter_core
// Splits EEPROM read and write requests into per-block bus transfers, cut at pages for writes.
// ----------------------------------------------------------------------------
// A request enters the front, which checks it, clips it at the chip end and
// registers it, then flags requests that exceed the 64-result limit and
// registers it again; it then waits in a two-entry queue. The segment
// sequencer loads a request and then emits one transfer per cycle while its
// result register is free, and it takes no new request until the last result
// of the current one is emitted. The sequencer's one-segment-per-cycle loop
// sets the sustained rate. PAGE_BYTES and BLOCK_BYTES must be powers of two.
module eeprom_transfer_splitter_core
   import ets_pkg::*;
#(
   parameter int PAGE_BYTES  = 16,
   parameter int BLOCK_BYTES = 256,
   parameter int BLOCK_COUNT = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [15:0] req_start_address,
   input  logic [15:0] req_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [6:0]  rsp_device_address,
   output logic [7:0]  rsp_word_address,
   output logic [8:0]  rsp_segment_length,
   output logic [9:0]  rsp_buffer_offset,
   output logic [1:0]  rsp_status,
   output logic        rsp_truncated,
   output logic        rsp_last
);

   logic [6:0] device_base_ff, device_base_in;
   logic       csr_write;
   logic       push_valid, push_ready, pop_valid, pop_ready;
   job_type    push_job, pop_job;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready && (paddr[2] == REG_DEVICE_BASE);
   assign device_base_in = csr_write ? pwdata[6:0] : device_base_ff;
   assign prdata = (paddr[2] == REG_DEVICE_BASE) ? {25'd0, device_base_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         device_base_ff <= DEVICE_BASE_RESET;
      end else begin
         device_base_ff <= device_base_in;
      end
   end

   ets_front #(
      .PAGE_BYTES  (PAGE_BYTES),
      .BLOCK_BYTES (BLOCK_BYTES),
      .BLOCK_COUNT (BLOCK_COUNT)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_start_address (req_start_address),
      .req_length        (req_length),
      .push_valid        (push_valid),
      .push_ready        (push_ready),
      .push_job          (push_job)
   );

   ets_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   ets_back #(
      .PAGE_BYTES  (PAGE_BYTES),
      .BLOCK_BYTES (BLOCK_BYTES),
      .BLOCK_COUNT (BLOCK_COUNT)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .device_base        (device_base_ff),
      .pop_valid          (pop_valid),
      .pop_ready          (pop_ready),
      .pop_job            (pop_job),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_device_address (rsp_device_address),
      .rsp_word_address   (rsp_word_address),
      .rsp_segment_length (rsp_segment_length),
      .rsp_buffer_offset  (rsp_buffer_offset),
      .rsp_status         (rsp_status),
      .rsp_truncated      (rsp_truncated),
      .rsp_last           (rsp_last)
   );

endmodule

@@ sim/ets_transfer_checker.sv @@
// ----------------------------------------------------------------------------
// ets_transfer_checker
// Watches the request, transfer and register ports of the EEPROM transfer
// splitter, works out the bus transfers each accepted request must produce,
// and compares every accepted transfer with the oldest outstanding one.
// ----------------------------------------------------------------------------
module ets_transfer_checker
   import ets_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_op,
   input  logic [15:0] req_start_address,
   input  logic [15:0] req_length,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [6:0]  rsp_device_address,
   input  logic [7:0]  rsp_word_address,
   input  logic [8:0]  rsp_segment_length,
   input  logic [9:0]  rsp_buffer_offset,
   input  logic [1:0]  rsp_status,
   input  logic        rsp_truncated,
   input  logic        rsp_last,
   output int          failures,
   output int          pending
);

   localparam int unsigned PAGE_BYTES  = 16;
   localparam int unsigned BLOCK_BYTES = 256;
   localparam int unsigned BLOCK_COUNT = 4;
   localparam int unsigned CHIP_BYTES  = BLOCK_BYTES * BLOCK_COUNT;

   typedef struct {
      logic [6:0] device_address;
      logic [7:0] word_address;
      logic [8:0] segment_length;
      logic [9:0] buffer_offset;
      status_type status;
      logic       truncated;
      logic       last;
   } transfer_type;

   transfer_type expected_transfers[$];
   logic [6:0]   device_base;

   task automatic push_error(input status_type code);
      transfer_type t;
      t.device_address = '0;
      t.word_address   = '0;
      t.segment_length = '0;
      t.buffer_offset  = '0;
      t.status         = code;
      t.truncated      = 1'b0;
      t.last           = 1'b1;
      expected_transfers.push_back(t);
   endtask

   task automatic split_request(input logic op, input logic [15:0] start,
                                input logic [15:0] len_in);
      transfer_type segs[$];
      transfer_type t;
      int unsigned  addr;
      int unsigned  remaining;
      int unsigned  off;
      int unsigned  word;
      int unsigned  seg;
      int unsigned  page_left;
      logic         cut;
      addr      = 32'(start);
      remaining = 32'(len_in);
      off       = 0;
      cut       = 1'b0;
      if (addr >= CHIP_BYTES) begin
         push_error(STATUS_RANGE);
      end else if (remaining == 0) begin
         push_error(STATUS_ZERO_LEN);
      end else begin
         if (remaining > CHIP_BYTES - addr) begin
            remaining = CHIP_BYTES - addr;
            cut = 1'b1;
         end
         while (remaining > 0 && segs.size() < MAX_RESULTS) begin
            word = addr % BLOCK_BYTES;
            seg  = BLOCK_BYTES - word;
            if (op == OP_WRITE) begin
               page_left = PAGE_BYTES - (word % PAGE_BYTES);
               if (page_left < seg) seg = page_left;
            end
            if (remaining < seg) seg = remaining;
            t.device_address = 7'(device_base + addr / BLOCK_BYTES);
            t.word_address   = 8'(word);
            t.segment_length = 9'(seg);
            t.buffer_offset  = 10'(off);
            t.status         = STATUS_OK;
            t.truncated      = 1'b0;
            t.last           = 1'b0;
            segs.push_back(t);
            addr      += seg;
            off       += seg;
            remaining -= seg;
         end
         if (remaining > 0) cut = 1'b1;
         for (int i = 0; i < segs.size(); i++) begin
            t = segs[i];
            t.truncated = cut;
            t.last = (i == segs.size() - 1);
            expected_transfers.push_back(t);
         end
      end
   endtask

   task automatic check_transfer();
      transfer_type e;
      if (expected_transfers.size() == 0) begin
         $error("unexpected transfer: device_address %0d word_address %0d length %0d",
                rsp_device_address, rsp_word_address, rsp_segment_length);
         failures++;
      end else begin
         e = expected_transfers.pop_front();
         if (rsp_device_address !== e.device_address) begin
            $error("device_address: expected %0d, actual %0d",
                   e.device_address, rsp_device_address);
            failures++;
         end
         if (rsp_word_address !== e.word_address) begin
            $error("word_address: expected %0d, actual %0d", e.word_address, rsp_word_address);
            failures++;
         end
         if (rsp_segment_length !== e.segment_length) begin
            $error("segment_length: expected %0d, actual %0d",
                   e.segment_length, rsp_segment_length);
            failures++;
         end
         if (rsp_buffer_offset !== e.buffer_offset) begin
            $error("buffer_offset: expected %0d, actual %0d",
                   e.buffer_offset, rsp_buffer_offset);
            failures++;
         end
         if (rsp_status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, rsp_status);
            failures++;
         end
         if (rsp_truncated !== e.truncated) begin
            $error("truncated: expected %0d, actual %0d", e.truncated, rsp_truncated);
            failures++;
         end
         if (rsp_last !== e.last) begin
            $error("last: expected %0d, actual %0d", e.last, rsp_last);
            failures++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         device_base = DEVICE_BASE_RESET;
         expected_transfers.delete();
      end else begin
         if (psel && penable && pwrite && pready && paddr[2] == REG_DEVICE_BASE)
            device_base = pwdata[6:0];
         if (rsp_valid && rsp_ready) check_transfer();
         if (req_valid && req_ready) split_request(req_op, req_start_address, req_length);
      end
      pending = expected_transfers.size();
   end

endmodule

@@ sim/eeprom_transfer_splitter_core_test.sv @@
// ----------------------------------------------------------------------------
// eeprom_transfer_splitter_core_test
// Drives read and write requests into the EEPROM transfer splitter through
// directed corner cases and random traffic over several device base settings
// and idle/stall mixes; a checker beside the block predicts every transfer.
// ----------------------------------------------------------------------------
module eeprom_transfer_splitter_core_test;
   import ets_pkg::*;

   localparam logic [2:0] ADDR_DEVICE_BASE = 3'd0;
   localparam int PHASE_ITEMS = 22;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_op = OP_READ;
   logic [15:0] req_start_address = '0;
   logic [15:0] req_length = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [6:0]  rsp_device_address;
   logic [7:0]  rsp_word_address;
   logic [8:0]  rsp_segment_length;
   logic [9:0]  rsp_buffer_offset;
   logic [1:0]  rsp_status;
   logic        rsp_truncated;
   logic        rsp_last;

   int failures;
   int pending;
   int idle_pct = 0;
   int stall_pct = 0;

   eeprom_transfer_splitter_core dut (
      .clock, .reset, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
      .req_valid, .req_ready, .req_op, .req_start_address, .req_length,
      .rsp_valid, .rsp_ready, .rsp_device_address, .rsp_word_address,
      .rsp_segment_length, .rsp_buffer_offset, .rsp_status, .rsp_truncated, .rsp_last
   );

   ets_transfer_checker transfer_check (
      .clock, .reset, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
      .req_valid, .req_ready, .req_op, .req_start_address, .req_length,
      .rsp_valid, .rsp_ready, .rsp_device_address, .rsp_word_address,
      .rsp_segment_length, .rsp_buffer_offset, .rsp_status, .rsp_truncated, .rsp_last,
      .failures, .pending
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #800000;
      $display("status: fail");
      $finish;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic send_request(input logic op, input logic [15:0] addr,
                               input logic [15:0] len);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid         = 1'b1;
      req_op            = op;
      req_start_address = addr;
      req_length        = len;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_device_base(input logic [6:0] value);
      @(negedge clock);
      psel    = 1'b1;
      pwrite  = 1'b1;
      paddr   = ADDR_DEVICE_BASE;
      pwdata  = {25'd0, value};
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic send_random_request();
      logic        op;
      logic [15:0] addr;
      logic [15:0] len;
      int          pick;
      op   = 1'($urandom_range(1));
      pick = $urandom_range(99);
      addr = 16'($urandom_range(1023));
      if (pick < 6) begin
         addr = 16'($urandom_range(65535, 1024));
         len  = 16'($urandom);
      end else if (pick < 11) begin
         len = 16'd0;
      end else if (pick < 19) begin
         len = 16'($urandom);
      end else if (pick < 25) begin
         len = 16'(1024 - addr);
      end else if (pick < 35) begin
         len = 16'($urandom_range(300, 1));
      end else begin
         len = 16'($urandom_range(48, 1));
      end
      send_request(op, addr, len);
   endtask

   task automatic run_phase(input int idle, input int stall);
      idle_pct  = idle;
      stall_pct = stall;
      repeat (PHASE_ITEMS) send_random_request();
      drain();
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // directed corners at the reset device base
      send_request(OP_READ,  16'd0,     16'd1);
      send_request(OP_WRITE, 16'd0,     16'd1);
      send_request(OP_READ,  16'd1023,  16'd1);
      send_request(OP_WRITE, 16'd1023,  16'd1);
      send_request(OP_READ,  16'd1024,  16'd1);
      send_request(OP_WRITE, 16'hFFFF,  16'hFFFF);
      send_request(OP_READ,  16'd0,     16'd0);
      send_request(OP_WRITE, 16'd1023,  16'd0);
      send_request(OP_READ,  16'd2000,  16'd0);
      send_request(OP_WRITE, 16'd0,     16'd1024);
      send_request(OP_READ,  16'd0,     16'd1024);
      send_request(OP_READ,  16'd0,     16'hFFFF);
      send_request(OP_WRITE, 16'd0,     16'hFFFF);
      send_request(OP_READ,  16'd0,     16'd256);
      send_request(OP_READ,  16'd255,   16'd2);
      send_request(OP_WRITE, 16'd15,    16'd2);
      send_request(OP_WRITE, 16'd5,     16'd100);
      send_request(OP_WRITE, 16'd250,   16'd20);
      send_request(OP_READ,  16'd1000,  16'd100);
      send_request(OP_WRITE, 16'd1000,  16'd100);
      send_request(OP_READ,  16'd768,   16'd256);
      send_request(OP_WRITE, 16'd16,    16'd16);
      drain();

      run_phase(0, 0);
      write_device_base(7'd0);
      run_phase(82, 0);
      write_device_base(7'd124);
      run_phase(0, 82);
      write_device_base(7'($urandom_range(124)));
      run_phase(31, 31);

      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/ets_pkg.sv
rtl/ets_front.sv
rtl/ets_queue.sv
rtl/ets_back.sv
rtl/eeprom_transfer_splitter_core.sv
sim/ets_transfer_checker.sv
sim/eeprom_transfer_splitter_core_test.sv
